@@ sv/assert_macros.svh @@
// Assertion macros included by acoustic_frame_sync
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ sv/afs_pkg.sv @@
// Types and constants of the acoustic frame synchroniser
package afs_pkg;

  localparam int RUN_WIDTH_DEF = 16;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int LEN_W         = 11;
  localparam int TABLE_LEN     = 10;

  localparam logic [LEN_W-1:0] DEFAULT_BLOCK = 11'd480;

  localparam logic [LEN_W-1:0] LEN_TABLE [TABLE_LEN] = '{
    11'd80, 11'd160, 11'd220, 11'd240, 11'd320,
    11'd441, 11'd480, 11'd882, 11'd960, 11'd1920
  };

  // register reset values
  localparam logic [14:0] LOUD_THR_RST   = 15'd25000;
  localparam logic [14:0] QUIET_THR_RST  = 15'd10000;
  localparam logic [15:0] START_NEED_RST = 16'd200;
  localparam logic [15:0] END_NEED_RST   = 16'd20;
  localparam logic [15:0] QUIET_NEED_RST = 16'd20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOUD_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_NEED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_NEED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_NEED = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SYNC = 3'd1,
    PH_PRE  = 3'd2,
    PH_DATA = 3'd3,
    PH_END  = 3'd4
  } phase_t;

  typedef struct packed {
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic               data_valid;
    logic signed [15:0] data_sample;
    logic [LEN_W-1:0]   block_position;
    logic               block_done;
    logic               block_dropped;
    logic               message_done;
    logic [LEN_W-1:0]   block_size;
    logic [2:0]         phase_now;
  } out_item_t;

endpackage

@@ sv/acoustic_frame_sync.sv @@
// Acoustic frame synchroniser: stereo samples in, framed left samples out.
//
// Input channel in_valid/in_ready/in_data carries one stereo sample pair per
// transaction; output channel out_valid/out_ready/out_data returns exactly one
// result per input transaction, in order. Samples move through an input
// register and a result register: out_valid rises when the result register
// loads; one sample per cycle is sustained while the receiver takes results.
// All framing state (phase, run counters, fill count, block length)
// updates in the single step between the two registers, which sets the rate.
// When the receiver stalls, the result register holds and the input register
// keeps its sample; in_ready drops only when both are full.
// Registers are written via cfg_we/cfg_index/cfg_data; the user, not the block,
// ensures no transaction is in flight; writes to unknown indexes are ignored.
// Synchronous reset rst empties both registers, returns to idle with all run
// counters cleared, block length 480, and register defaults.
module acoustic_frame_sync
  import afs_pkg::*;
#(
  parameter int RUN_WIDTH = RUN_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  `include "assert_macros.svh"

  localparam int CW    = (RUN_WIDTH > CFG_W) ? RUN_WIDTH : CFG_W;
  localparam int TGT_W = RUN_WIDTH + 4;
  localparam logic [RUN_WIDTH-1:0] RUN_MAX = {RUN_WIDTH{1'b1}};

  // configuration
  logic [14:0] loud_thr, quiet_thr;
  logic [15:0] start_need, end_need, quiet_need;

  always_ff @(posedge clk) begin
    if (rst) begin
      loud_thr   <= LOUD_THR_RST;
      quiet_thr  <= QUIET_THR_RST;
      start_need <= START_NEED_RST;
      end_need   <= END_NEED_RST;
      quiet_need <= QUIET_NEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOUD_THR:   loud_thr   <= cfg_data[14:0];
        REG_QUIET_THR:  quiet_thr  <= cfg_data[14:0];
        REG_START_NEED: start_need <= cfg_data;
        REG_END_NEED:   end_need   <= cfg_data;
        REG_QUIET_NEED: quiet_need <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic     s1_valid;
  in_item_t s1_item;
  logic     advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_data;
    end
  end

  // framing state
  phase_t             phase, phase_next;
  logic [RUN_WIDTH-1:0] start_run, start_run_next;
  logic [RUN_WIDTH-1:0] end_run, end_run_next;
  logic [RUN_WIDTH-1:0] quiet_run, quiet_run_next;
  logic [LEN_W-1:0]   fill_count, fill_count_next;
  logic [LEN_W-1:0]   block_length, block_length_next;
  out_item_t          res;

  logic signed [15:0] l, r;
  logic [16:0]        lx, rx, al, ar;
  logic               loud, quiet, sound;
  logic [TGT_W-1:0]   tgt10;
  logic [LEN_W-1:0]   nearest;
  logic [LEN_W-1:0]   fill_inc;
  logic [RUN_WIDTH-1:0] start_inc, end_inc, quiet_inc;

  assign l  = s1_item.left_in;
  assign r  = s1_item.right_in;
  assign lx = {l[15], l};
  assign rx = {r[15], r};
  // magnitude of -32768 comes out as 32768 in 17 bits
  assign al = lx[16] ? (~lx + 17'd1) : lx;
  assign ar = rx[16] ? (~rx + 17'd1) : rx;

  assign loud  = (al > {2'b00, loud_thr}) && (ar > {2'b00, loud_thr});
  assign quiet = (al < {2'b00, quiet_thr}) && (ar < {2'b00, quiet_thr});
  assign sound = (al > {2'b00, quiet_thr}) || (ar > {2'b00, quiet_thr});

  assign start_inc = (start_run == RUN_MAX) ? RUN_MAX : start_run + 1'b1;
  assign end_inc   = (end_run == RUN_MAX) ? RUN_MAX : end_run + 1'b1;
  assign quiet_inc = (quiet_run == RUN_MAX) ? RUN_MAX : quiet_run + 1'b1;
  assign fill_inc  = fill_count + 1'b1;

  // nearest table entry to 5*q: entry i wins while 10*q <= t[i] + t[i+1],
  // which also hands ties to the smaller entry
  assign tgt10 = {1'b0, quiet_run, 3'b000} + {3'b000, quiet_run, 1'b0};

  always_comb begin
    nearest = LEN_TABLE[TABLE_LEN-1];
    for (int i = TABLE_LEN - 2; i >= 0; i--) begin
      if (tgt10 <= TGT_W'({1'b0, LEN_TABLE[i]} + {1'b0, LEN_TABLE[i+1]})) begin
        nearest = LEN_TABLE[i];
      end
    end
  end

  always_comb begin
    phase_next        = phase;
    start_run_next    = start_run;
    end_run_next      = end_run;
    quiet_run_next    = quiet_run;
    fill_count_next   = fill_count;
    block_length_next = block_length;
    res               = '0;

    unique case (phase)
      PH_SYNC, PH_PRE: begin
        if (quiet) begin
          quiet_run_next = quiet_inc;
        end else begin
          if (CW'(quiet_run) >= CW'(quiet_need) && sound) begin
            if (phase == PH_SYNC) begin
              block_length_next = nearest;
            end
            phase_next = PH_DATA;
          end
          quiet_run_next = '0;
        end
      end
      PH_DATA: begin
        res.data_valid     = 1'b1;
        res.data_sample    = l;
        res.block_position = fill_count;
        fill_count_next    = fill_inc;
        if (fill_inc >= block_length) begin
          res.block_done  = 1'b1;
          fill_count_next = '0;
          phase_next      = PH_PRE;
        end
        if ($signed(l) < $signed(r) && loud) begin
          end_run_next = end_inc;
          if (CW'(end_inc) >= CW'(end_need)) begin
            end_run_next      = '0;
            fill_count_next   = '0;
            res.block_dropped = 1'b1;
            phase_next        = PH_END;
          end
        end else begin
          end_run_next = '0;
        end
      end
      PH_END: begin
        res.message_done = 1'b1;
        phase_next       = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
        if ($signed(l) > $signed(r) && loud) begin
          start_run_next = start_inc;
          if (CW'(start_inc) >= CW'(start_need)) begin
            start_run_next = '0;
            phase_next     = PH_SYNC;
          end
        end else begin
          start_run_next = '0;
        end
      end
    endcase

    res.block_size = block_length_next;
    res.phase_now  = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      start_run    <= '0;
      end_run      <= '0;
      quiet_run    <= '0;
      fill_count   <= '0;
      block_length <= DEFAULT_BLOCK;
    end else if (advance) begin
      phase        <= phase_next;
      start_run    <= start_run_next;
      end_run      <= end_run_next;
      quiet_run    <= quiet_run_next;
      fill_count   <= fill_count_next;
      block_length <= block_length_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  `ASSERT_IMPLIES(a_done_leaves_data, clk, rst,
                  out_valid && out_data.block_done,
                  out_data.phase_now == PH_PRE || out_data.phase_now == PH_END)
  `ASSERT_IMPLIES(a_pos_in_block, clk, rst,
                  out_valid && out_data.data_valid,
                  out_data.block_position < out_data.block_size)
  `ASSERT_NEXT(a_end_to_idle, clk, rst,
               advance && phase == PH_END, phase == PH_IDLE)
  `ASSERT_NEXT(a_held_item_kept, clk, rst,
               s1_valid && !advance, s1_valid && $stable(s1_item))

endmodule
